// File: hw/rtl/jpe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jpe_pkg
// Shared widths, register indexes, datapath opcodes and helpers for the
// Jacobi polynomial evaluator.
// ----------------------------------------------------------------------------
package jpe_pkg;

    localparam int PT_W           = 32;
    localparam int RES_W          = 48;
    localparam int DEG_W          = 5;
    localparam int AB_W           = 4;
    localparam int STEP_W         = 6;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 5;
    localparam int DEF_MAX_DEGREE = 31;
    localparam int DEF_FRAC_BITS  = 30;
    localparam int CHUNK_W        = 16;
    localparam int CHUNKS         = RES_W / CHUNK_W;
    localparam int COEF_W         = 22;

    localparam logic [CFG_IDX_W-1:0] REG_DEGREE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BETA   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd3;

    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NONE   = 4'd0;
    localparam logic [OP_W-1:0] OP_INIT   = 4'd1;
    localparam logic [OP_W-1:0] OP_COEFA  = 4'd2;
    localparam logic [OP_W-1:0] OP_COEFB  = 4'd3;
    localparam logic [OP_W-1:0] OP_TERM   = 4'd4;
    localparam logic [OP_W-1:0] OP_MUL    = 4'd5;
    localparam logic [OP_W-1:0] OP_SUM    = 4'd6;
    localparam logic [OP_W-1:0] OP_DIV    = 4'd7;
    localparam logic [OP_W-1:0] OP_UPDATE = 4'd8;
    localparam logic [OP_W-1:0] OP_FINAL  = 4'd9;
    localparam logic [OP_W-1:0] OP_LOAD   = 4'd10;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [STEP_W-1:0] step;
    } t_dp_cmd;

    typedef struct packed {
        logic signed [RES_W-1:0] value;
        logic                    ovf;
    } t_sat;

    // (c2 << F) + c3 * x
    function automatic int term_width(input int f);
        int a;
        a = 18 + f;
        return ((a > COEF_W + PT_W + 1) ? a : COEF_W + PT_W + 1) + 1;
    endfunction

    // (t * cur) - (c4 * prev << F)
    function automatic int num_width(input int f);
        int a;
        int b;
        a = term_width(f) + RES_W + 1;
        b = COEF_W + RES_W + 1 + f;
        return ((a > b) ? a : b) + 1;
    endfunction

    function automatic int quot_width(input int f);
        int q;
        q = num_width(f) - f;
        return q + (q % 2);
    endfunction

    function automatic t_sat sat48(input logic signed [127:0] v);
        t_sat r;
        logic signed [127:0] hi;
        logic signed [127:0] lo;
        hi = (128'sd1 <<< (RES_W - 1)) - 128'sd1;
        lo = -hi - 128'sd1;
        if (v > hi) begin
            r.value = hi[RES_W-1:0];
            r.ovf   = 1'b1;
        end else if (v < lo) begin
            r.value = lo[RES_W-1:0];
            r.ovf   = 1'b1;
        end else begin
            r.value = v[RES_W-1:0];
            r.ovf   = 1'b0;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/jpe_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jpe_datapath
// Recurrence datapath: coefficients, chunked multiply, radix-4 restoring
// divider, saturation and derivative scaling.
// ----------------------------------------------------------------------------
module jpe_datapath #(
    parameter int FRAC_BITS = jpe_pkg::DEF_FRAC_BITS
) (
    input  logic                                 i_clk,
    input  jpe_pkg::t_dp_cmd                     i_cmd,
    input  logic signed [jpe_pkg::PT_W-1:0]      i_point,
    input  logic [jpe_pkg::AB_W-1:0]             i_alpha,
    input  logic [jpe_pkg::AB_W-1:0]             i_beta,
    input  logic                                 i_mode,
    input  logic [jpe_pkg::STEP_W-1:0]           i_degree,
    output logic signed [jpe_pkg::RES_W-1:0]     o_result_value,
    output logic                                 o_overflow
);
    import jpe_pkg::*;

    localparam int TW = term_width(FRAC_BITS);
    localparam int PW = TW + RES_W;
    localparam int NW = num_width(FRAC_BITS);
    localparam int QE = quot_width(FRAC_BITS);
    localparam int VW = ((FRAC_BITS + 6 > PT_W + 7) ? FRAC_BITS + 6 : PT_W + 7) + 1;

    localparam logic signed [RES_W-1:0] ONE = RES_W'(1) << FRAC_BITS;

    logic signed [PT_W-1:0]      r_x;
    logic [4:0]                  r_ae;
    logic [4:0]                  r_be;
    logic [5:0]                  r_ab;
    logic signed [9:0]           r_d;
    logic [7:0]                  r_e;
    logic [13:0]                 r_u1;
    logic [14:0]                 r_u3;
    logic [13:0]                 r_u4;
    logic signed [17:0]          r_c2;
    logic [COEF_W-1:0]           r_c1;
    logic [COEF_W-1:0]           r_c3;
    logic [COEF_W-1:0]           r_c4;
    logic [TW-1:0]               r_tmag;
    logic                        r_pneg;
    logic signed [COEF_W+RES_W:0] r_p2;
    logic [RES_W-1:0]            r_curmag;
    logic [PW-1:0]               r_acc;
    logic                        r_nneg;
    logic [QE-1:0]               r_dvd;
    logic [COEF_W-1:0]           r_rem;
    logic [QE-1:0]               r_quo;
    logic signed [RES_W-1:0]     r_cur;
    logic signed [RES_W-1:0]     r_prev;
    logic                        r_ovf;
    logic signed [RES_W-1:0]     r_res;
    logic                        r_res_ovf;

    // first order term
    logic [4:0]                  ae;
    logic [4:0]                  be;
    logic [5:0]                  sum2;
    logic signed [5:0]           dab;
    logic signed [PT_W+6:0]      p1_mul;
    logic signed [VW-1:0]        p1_sum;
    logic signed [VW-1:0]        p1_rnd;
    logic signed [VW-1:0]        p1_half;
    logic signed [9:0]           d_sq;
    t_sat                        p1_sat;

    assign ae      = {1'b0, i_alpha} + {4'b0, i_mode};
    assign be      = {1'b0, i_beta} + {4'b0, i_mode};
    assign sum2    = {1'b0, ae} + {1'b0, be} + 6'd2;
    assign dab     = $signed({1'b0, ae}) - $signed({1'b0, be});
    assign p1_mul  = $signed({1'b0, sum2}) * r_x;
    assign p1_sum  = (VW'(dab) <<< FRAC_BITS) + VW'(p1_mul);
    assign p1_rnd  = p1_sum + $signed({{(VW-1){1'b0}}, p1_sum[VW-1]});
    assign p1_half = p1_rnd >>> 1;
    assign p1_sat  = sat48(128'(p1_half));
    assign d_sq    = $signed({1'b0, 9'(ae * ae)}) - $signed({1'b0, 9'(be * be)});

    // coefficients
    logic [7:0]  e_n;
    logic [7:0]  sp1;
    logic [7:0]  sab1;
    logic [7:0]  sa;
    logic [7:0]  sb;
    logic [15:0] u1_w;
    logic [15:0] u3_w;
    logic [15:0] u4_w;
    logic signed [18:0] c2_w;
    logic [7:0]  e2;
    logic [22:0] c1_w;
    logic [22:0] c3_w;
    logic [22:0] c4_w;

    assign e_n  = {1'b0, i_cmd.step, 1'b0} + {2'b0, r_ab};
    assign sp1  = {2'b0, i_cmd.step} + 8'd1;
    assign sab1 = {2'b0, i_cmd.step} + {2'b0, r_ab} + 8'd1;
    assign sa   = {2'b0, i_cmd.step} + {3'b0, r_ae};
    assign sb   = {2'b0, i_cmd.step} + {3'b0, r_be};
    assign u1_w = 16'(sp1 * sab1) << 1;
    assign u3_w = 16'(e_n * (e_n + 8'd1));
    assign u4_w = 16'(sa * sb) << 1;
    assign c2_w = $signed({1'b0, 9'({1'b0, e_n} + 9'd1)}) * r_d;
    assign e2   = r_e + 8'd2;
    assign c1_w = 23'(r_u1 * r_e);
    assign c3_w = 23'(r_u3 * e2);
    assign c4_w = 23'(r_u4 * e2);

    // term and second product
    logic signed [COEF_W+PT_W:0]  c3x;
    logic signed [TW-1:0]         t_w;
    logic [TW-1:0]                tmag_w;
    logic signed [COEF_W+RES_W:0] p2_w;
    logic [RES_W-1:0]             curmag_w;

    assign c3x      = $signed({1'b0, r_c3}) * r_x;
    assign t_w      = (TW'(r_c2) <<< FRAC_BITS) + TW'(c3x);
    assign tmag_w   = t_w[TW-1] ? TW'(-t_w) : TW'(t_w);
    assign p2_w     = $signed({1'b0, r_c4}) * r_prev;
    assign curmag_w = r_cur[RES_W-1] ? RES_W'(-r_cur) : RES_W'(r_cur);

    logic [TW+CHUNK_W-1:0] mul_pp;
    assign mul_pp = r_tmag * r_curmag[RES_W-1 -: CHUNK_W];

    // numerator
    logic signed [NW-1:0] p1s;
    logic signed [NW-1:0] num;
    logic [NW-1:0]        nmag;

    assign p1s  = r_pneg ? -$signed(NW'(r_acc)) : $signed(NW'(r_acc));
    assign num  = p1s - (NW'(r_p2) <<< FRAC_BITS);
    assign nmag = num[NW-1] ? NW'(-num) : NW'(num);

    // two quotient bits per cycle
    logic [COEF_W:0]   rem1;
    logic [COEF_W:0]   rem1b;
    logic [COEF_W:0]   rem2;
    logic [COEF_W:0]   rem2b;
    logic              qb1;
    logic              qb2;

    assign rem1  = {r_rem, r_dvd[QE-1]};
    assign qb1   = rem1 >= {1'b0, r_c1};
    assign rem1b = qb1 ? rem1 - {1'b0, r_c1} : rem1;
    assign rem2  = {rem1b[COEF_W-1:0], r_dvd[QE-2]};
    assign qb2   = rem2 >= {1'b0, r_c1};
    assign rem2b = qb2 ? rem2 - {1'b0, r_c1} : rem2;

    logic signed [127:0] qv;
    t_sat                q_sat;
    assign qv    = r_nneg ? -$signed(128'(r_quo)) : $signed(128'(r_quo));
    assign q_sat = sat48(qv);

    // derivative scale
    logic [7:0]                k_w;
    logic signed [RES_W+7:0]   fin_prod;
    logic signed [RES_W+7:0]   fin_rnd;
    logic signed [RES_W+7:0]   fin_half;
    t_sat                      fin_sat;

    assign k_w      = {4'b0, i_alpha} + {4'b0, i_beta} + {2'b0, i_degree} + 8'd1;
    assign fin_prod = r_cur * $signed({1'b0, k_w[6:0]});
    assign fin_rnd  = fin_prod + $signed({{(RES_W+7){1'b0}}, fin_prod[RES_W+7]});
    assign fin_half = fin_rnd >>> 1;
    assign fin_sat  = sat48(128'(fin_half));

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_x <= i_point;
            end
            OP_INIT: begin
                r_ae   <= ae;
                r_be   <= be;
                r_ab   <= {1'b0, ae} + {1'b0, be};
                r_d    <= d_sq;
                r_prev <= ONE;
                if (i_cmd.step == '0) begin
                    r_cur <= ONE;
                    r_ovf <= 1'b0;
                end else begin
                    r_cur <= p1_sat.value;
                    r_ovf <= p1_sat.ovf;
                end
            end
            OP_COEFA: begin
                r_e  <= e_n;
                r_u1 <= u1_w[13:0];
                r_u3 <= u3_w[14:0];
                r_u4 <= u4_w[13:0];
                r_c2 <= c2_w[17:0];
            end
            OP_COEFB: begin
                r_c1 <= c1_w[COEF_W-1:0];
                r_c3 <= c3_w[COEF_W-1:0];
                r_c4 <= c4_w[COEF_W-1:0];
            end
            OP_TERM: begin
                r_tmag   <= tmag_w;
                r_pneg   <= t_w[TW-1] ^ r_cur[RES_W-1];
                r_p2     <= p2_w;
                r_curmag <= curmag_w;
                r_acc    <= '0;
            end
            OP_MUL: begin
                r_acc    <= (r_acc << CHUNK_W) + PW'(mul_pp);
                r_curmag <= r_curmag << CHUNK_W;
            end
            OP_SUM: begin
                r_nneg <= num[NW-1];
                r_dvd  <= QE'(nmag[NW-1:FRAC_BITS]);
                r_rem  <= '0;
                r_quo  <= '0;
            end
            OP_DIV: begin
                r_rem <= rem2b[COEF_W-1:0];
                r_dvd <= r_dvd << 2;
                r_quo <= {r_quo[QE-3:0], qb1, qb2};
            end
            OP_UPDATE: begin
                r_prev <= r_cur;
                r_cur  <= q_sat.value;
                r_ovf  <= r_ovf | q_sat.ovf;
            end
            OP_FINAL: begin
                if (!i_mode) begin
                    r_res     <= r_cur;
                    r_res_ovf <= r_ovf;
                end else if (i_degree == '0) begin
                    r_res     <= '0;
                    r_res_ovf <= 1'b0;
                end else begin
                    r_res     <= fin_sat.value;
                    r_res_ovf <= r_ovf | fin_sat.ovf;
                end
            end
            default: ;
        endcase
    end

    assign o_result_value = r_res;
    assign o_overflow     = r_res_ovf;

endmodule
`default_nettype wire

// File: hw/rtl/jpe_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jpe_controller
// Sequencer for the recurrence: issues one datapath command per cycle and
// counts multiply chunks, divider cycles and recurrence steps.
// ----------------------------------------------------------------------------
module jpe_controller #(
    parameter int FRAC_BITS = jpe_pkg::DEF_FRAC_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    input  logic [jpe_pkg::STEP_W-1:0] i_degree,
    input  logic                       i_mode,
    output logic                       busy,
    output logic                       o_valid,
    output jpe_pkg::t_dp_cmd           o_cmd
);
    import jpe_pkg::*;

    localparam int DIV_CYC = quot_width(FRAC_BITS) / 2;
    localparam int CNT_W   = $clog2(DIV_CYC + 1);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_INIT  = 4'd1;
    localparam logic [3:0] ST_COEFA = 4'd2;
    localparam logic [3:0] ST_COEFB = 4'd3;
    localparam logic [3:0] ST_TERM  = 4'd4;
    localparam logic [3:0] ST_MUL   = 4'd5;
    localparam logic [3:0] ST_SUM   = 4'd6;
    localparam logic [3:0] ST_DIV   = 4'd7;
    localparam logic [3:0] ST_UPD   = 4'd8;
    localparam logic [3:0] ST_FINAL = 4'd9;

    logic [3:0]        r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic [STEP_W-1:0] r_m, n_m;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_valid;

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_m        = r_m;
        n_cnt      = r_cnt;
        o_cmd.op   = OP_NONE;
        o_cmd.step = r_step;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.op = OP_LOAD;
                    if (i_mode && i_degree != '0) begin
                        n_m = i_degree - STEP_W'(1);
                    end else if (i_mode) begin
                        n_m = '0;
                    end else begin
                        n_m = i_degree;
                    end
                    n_state = ST_INIT;
                end
            end
            ST_INIT: begin
                o_cmd.op   = OP_INIT;
                o_cmd.step = r_m;
                n_step     = STEP_W'(1);
                n_state    = (r_m <= STEP_W'(1)) ? ST_FINAL : ST_COEFA;
            end
            ST_COEFA: begin
                o_cmd.op = OP_COEFA;
                n_state  = ST_COEFB;
            end
            ST_COEFB: begin
                o_cmd.op = OP_COEFB;
                n_state  = ST_TERM;
            end
            ST_TERM: begin
                o_cmd.op = OP_TERM;
                n_cnt    = '0;
                n_state  = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.op = OP_MUL;
                n_cnt    = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(CHUNKS - 1)) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                o_cmd.op = OP_SUM;
                n_cnt    = '0;
                n_state  = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.op = OP_DIV;
                n_cnt    = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_CYC - 1)) begin
                    n_state = ST_UPD;
                end
            end
            ST_UPD: begin
                o_cmd.op = OP_UPDATE;
                n_step   = r_step + STEP_W'(1);
                n_state  = (n_step == r_m) ? ST_FINAL : ST_COEFA;
            end
            ST_FINAL: begin
                o_cmd.op = OP_FINAL;
                n_state  = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_m     <= '0;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_m     <= n_m;
            r_cnt   <= n_cnt;
            r_valid <= (r_state == ST_FINAL);
        end
    end

    assign busy    = (r_state != ST_IDLE);
    assign o_valid = r_valid;

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_state == ST_IDLE)
        else $error("result strobe outside idle");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not start");
    a_final_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_FINAL |=> o_valid)
        else $error("final without result strobe");
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_UPD |-> r_step < r_m)
        else $error("recurrence step past degree");

endmodule
`default_nettype wire

// File: hw/rtl/jacobi_polynomial_evaluator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jacobi_polynomial_evaluator
// Jacobi polynomial or derivative at a Q1.30 point, Q17.30 saturated result.
// The radix-4 divider produces 76 quotient bits at 30 fraction bits, and
// the divider loop dominates the latency. One item at a time; busy drops in
// the result strobe cycle, where the next start is taken. No stall.
// Synchronous active-low reset clears the configuration registers and the sequencer.
// ----------------------------------------------------------------------------
module jacobi_polynomial_evaluator #(
    parameter int MAX_DEGREE = jpe_pkg::DEF_MAX_DEGREE,
    parameter int FRAC_BITS  = jpe_pkg::DEF_FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    input  logic signed [jpe_pkg::PT_W-1:0]     i_point,
    output logic                                busy,
    output logic                                o_valid,
    output logic signed [jpe_pkg::RES_W-1:0]    o_result_value,
    output logic                                o_overflow,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [jpe_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [jpe_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import jpe_pkg::*;

    logic [DEG_W-1:0] r_degree;
    logic [AB_W-1:0]  r_alpha;
    logic [AB_W-1:0]  r_beta;
    logic             r_mode;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree <= '0;
            r_alpha  <= '0;
            r_beta   <= '0;
            r_mode   <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_DEGREE: r_degree <= i_cfg_data[DEG_W-1:0];
                REG_ALPHA:  r_alpha  <= i_cfg_data[AB_W-1:0];
                REG_BETA:   r_beta   <= i_cfg_data[AB_W-1:0];
                REG_MODE:   r_mode   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic [STEP_W-1:0] deg_eff;
    assign deg_eff = (STEP_W'(r_degree) > STEP_W'(MAX_DEGREE)) ?
                     STEP_W'(MAX_DEGREE) : STEP_W'(r_degree);

    t_dp_cmd dp_cmd;

    jpe_controller #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_degree (deg_eff),
        .i_mode   (r_mode),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_cmd    (dp_cmd)
    );

    jpe_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_cmd          (dp_cmd),
        .i_point        (i_point),
        .i_alpha        (r_alpha),
        .i_beta         (r_beta),
        .i_mode         (r_mode),
        .i_degree       (deg_eff),
        .o_result_value (o_result_value),
        .o_overflow     (o_overflow)
    );

endmodule
`default_nettype wire

// File: verif/tb_jacobi_polynomial_evaluator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_jacobi_polynomial_evaluator
// Drives evaluation points in phases of fixed degree/alpha/beta/mode and
// checks each result against a fixed-point recurrence computed here.
// ----------------------------------------------------------------------------
module tb_jacobi_polynomial_evaluator;
    import jpe_pkg::*;

    localparam int       WATCHDOG_LIMIT = 40000;
    localparam longint   SAT_HI = (64'sd1 <<< 47) - 1;
    localparam longint   SAT_LO = -SAT_HI - 1;
    localparam longint   ONE_Q  = 64'sd1 <<< 30;

    typedef struct {
        logic signed [RES_W-1:0] value;
        bit                      ovf;
    } t_expect;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic signed [PT_W-1:0]    i_point = '0;
    logic                      busy;
    logic                      o_valid;
    logic signed [RES_W-1:0]   o_result_value;
    logic                      o_overflow;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]     i_cfg_data = '0;

    logic signed [PT_W-1:0]    point_q[$];
    t_expect                   result_q[$];
    int                        n_deg = 0, n_alpha = 0, n_beta = 0;
    bit                        n_mode = 1'b0;
    int                        errors = 0;
    int                        gap_cnt = 0;
    int                        stall_cnt = 0;
    bit                        took = 1'b0;

    jacobi_polynomial_evaluator uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_point(i_point),
        .busy(busy), .o_valid(o_valid), .o_result_value(o_result_value),
        .o_overflow(o_overflow), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    function automatic longint clamp48(logic signed [127:0] v, inout bit ovf);
        if (v > SAT_HI) begin
            ovf = 1'b1;
            return SAT_HI;
        end
        if (v < SAT_LO) begin
            ovf = 1'b1;
            return SAT_LO;
        end
        return longint'(v);
    endfunction

    function automatic longint jacobi_at(int n, longint a, longint b, longint x,
                                         inout bit ovf);
        longint prev, cur, s, c1, c2, c3, c4, t;
        logic signed [127:0] tw, cw, pw, qw, num, dv;
        prev = ONE_Q;
        if (n == 0) return ONE_Q;
        cur = clamp48(((a - b) * ONE_Q + (a + b + 2) * x) / 2, ovf);
        for (int i = 1; i < n; i++) begin
            s  = i;
            c1 = 2 * (s + 1) * (s + a + b + 1) * (2 * s + a + b);
            c2 = (2 * s + a + b + 1) * (a * a - b * b);
            c3 = (2 * s + a + b) * (2 * s + a + b + 1) * (2 * s + a + b + 2);
            c4 = 2 * (s + a) * (s + b) * (2 * s + a + b + 2);
            t  = c2 * ONE_Q + c3 * x;
            tw = t;
            cw = cur;
            pw = c4 * ONE_Q;
            qw = prev;
            dv = c1 * ONE_Q;
            num = tw * cw - pw * qw;
            prev = cur;
            cur = clamp48(num / dv, ovf);
        end
        return cur;
    endfunction

    function automatic t_expect evaluate(logic signed [PT_W-1:0] pt);
        t_expect e;
        bit ovf;
        longint p, v, x;
        ovf = 1'b0;
        x = pt;
        if (n_mode) begin
            if (n_deg == 0) begin
                v = 0;
            end else begin
                p = jacobi_at(n_deg - 1, n_alpha + 1, n_beta + 1, x, ovf);
                v = clamp48(p * (n_alpha + n_beta + n_deg + 1) / 2, ovf);
            end
        end else begin
            v = jacobi_at(n_deg, n_alpha, n_beta, x, ovf);
        end
        e.value = v[RES_W-1:0];
        e.ovf = ovf;
        return e;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 5) return $urandom_range(20, 200);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 4);
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !took) begin
            start <= 1'b1;
        end else if (gap_cnt > 0) begin
            gap_cnt <= gap_cnt - 1;
            start <= 1'b0;
        end else if (point_q.size() > 0) begin
            start <= 1'b1;
            i_point <= point_q.pop_front();
            gap_cnt <= pick_gap();
        end else begin
            start <= 1'b0;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_expect e;
        took <= start && !busy && i_rst_n;
        if (i_rst_n) begin
            if (o_valid) begin
                if (result_q.size() == 0) begin
                    $error("result with nothing outstanding: value %0d", o_result_value);
                    errors++;
                end else begin
                    e = result_q.pop_front();
                    if (o_result_value !== e.value) begin
                        $error("result_value expected %0d actual %0d", e.value,
                               o_result_value);
                        errors++;
                    end
                    if (o_overflow !== e.ovf) begin
                        $error("overflow expected %0d actual %0d", e.ovf, o_overflow);
                        errors++;
                    end
                end
            end
            if (start && !busy) result_q.push_back(evaluate(i_point));
            if ((start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready))
                stall_cnt <= 0;
            else
                stall_cnt <= stall_cnt + 1;
            if (stall_cnt >= WATCHDOG_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[CFG_DATA_W-1:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_DEGREE: n_deg   = val & 31;
            REG_ALPHA:  n_alpha = val & 15;
            REG_BETA:   n_beta  = val & 15;
            REG_MODE:   n_mode  = val[0];
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_cfg(int d, int a, int b, int m);
        write_reg(REG_DEGREE, d);
        write_reg(REG_ALPHA, a);
        write_reg(REG_BETA, b);
        write_reg(REG_MODE, m);
    endtask

    task automatic drain();
        @(posedge i_clk);
        while (point_q.size() != 0 || result_q.size() != 0 || start || busy)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic directed(int d, int a, int b, int m);
        set_cfg(d, a, b, m);
        point_q.push_back(32'sh8000_0000);
        point_q.push_back(32'sh7fff_ffff);
        point_q.push_back(32'sh4000_0000);
        point_q.push_back(-32'sh4000_0000);
        point_q.push_back(32'sd0);
        drain();
    endtask

    initial begin
        int d, cnt;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // reset config: degree zero, value mode
        point_q.push_back(32'sh1234_5678);
        drain();
        directed(0, 0, 0, 1);
        directed(31, 15, 15, 0);
        directed(31, 15, 0, 1);
        directed(1, 0, 15, 0);
        for (int ph = 0; ph < 16; ph++) begin
            if (ph % 5 == 4) d = 31;
            else if ($urandom_range(0, 3) == 0) d = $urandom_range(0, 31);
            else d = $urandom_range(0, 8);
            set_cfg(d, $urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 1));
            cnt = (d > 12) ? 6 : 30;
            for (int k = 0; k < cnt; k++) begin
                if ($urandom_range(0, 3) == 0)
                    point_q.push_back($signed($urandom()));
                else
                    point_q.push_back($signed($urandom_range(0, 32'h8000_0000))
                                      - 32'sh4000_0000);
            end
            drain();
        end
        repeat (50) @(posedge i_clk);
        if (errors == 0 && result_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

// File: files.f
hw/rtl/jpe_pkg.sv
hw/rtl/jpe_datapath.sv
hw/rtl/jpe_controller.sv
hw/rtl/jacobi_polynomial_evaluator.sv
verif/tb_jacobi_polynomial_evaluator.sv
